[sv/ihbrs_pkg.sv]
// Package for the isochronous half-buffer refill scheduler.
// Holds widths, step counts, register indexes and the sequencer state type.
// No dependencies.
`default_nettype none

package ihbrs_pkg;

	// bus cycle numbers per second; cycle values are reduced modulo this
	localparam int unsigned CYCLES_PER_SECOND = 8000;

	// field and datapath widths
	localparam int unsigned CYC_W   = 13;  // cycle numbers and half size
	localparam int unsigned DVS_W   = 14;  // divisor of the shared step unit
	localparam int unsigned CNT64_W = 64;  // running totals
	localparam int unsigned LATE_W  = 16;  // saturating late counter
	localparam int unsigned STEP_W  = 7;   // step counter, holds DIV_STEPS
	localparam int unsigned EMIT_W  = 6;   // refills given in one poll

	// step count of the shared restoring divide unit
	localparam int unsigned DIV_STEPS = CNT64_W;

	localparam int unsigned LATE_GAP    = 32;
	localparam int unsigned MAX_REFILLS = 63;
	localparam int unsigned HALF_RESET  = 320;

	// configuration register indexes
	localparam logic [1:0] REG_START_CYCLE    = 2'd0;
	localparam logic [1:0] REG_FIRST_TX_CYCLE = 2'd1;
	localparam logic [1:0] REG_HALF_PACKETS   = 2'd2;
	localparam logic [1:0] REG_ENABLED        = 2'd3;

	// sequencer states, one-hot
	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_GAP    = 8'b0000_0010,
		S_ACC    = 8'b0000_0100,
		S_LEAD   = 8'b0000_1000,
		S_DIV    = 8'b0001_0000,
		S_CMP    = 8'b0010_0000,
		S_REFILL = 8'b0100_0000,
		S_STATUS = 8'b1000_0000
	} state_t;

endpackage

`default_nettype wire

[sv/isoch_half_buffer_refill_scheduler.sv]
// Isochronous half-buffer refill scheduler: one shared restoring divide step
// unit under a one-hot sequencer. Depends on ihbrs_pkg.
// Sequence: a disabled poll (or half size zero) gives its status item in the
// cycle after the item is taken; otherwise the gap, total and lead steps run,
// and a poll before the lead is passed then gives its status item; else 64
// divide steps and one compare follow, then refills alternate with compares.
// Throughput: one poll at a time; the next item is taken after the status item.
// Reset (arst_n low, asynchronous): control registers reset, totals clear.
`default_nettype none

module isoch_half_buffer_refill_scheduler (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write port
	input  wire logic                              cfg_we,
	input  wire logic [1:0]                        cfg_index,
	input  wire logic [ihbrs_pkg::CYC_W-1:0]       cfg_data,
	// poll channel
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [ihbrs_pkg::CYC_W-1:0]       current_cycle,
	// result channel
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   is_refill,
	output logic                                   half_index,
	output logic [ihbrs_pkg::CYC_W-1:0]            packet_offset,
	output logic                                   late_poll,
	output logic [ihbrs_pkg::LATE_W-1:0]           late_poll_count,
	output logic                                   last
);

	localparam int unsigned CW   = ihbrs_pkg::CYC_W;
	localparam int unsigned DW   = ihbrs_pkg::DVS_W;
	localparam int unsigned QW   = ihbrs_pkg::CNT64_W;
	localparam int unsigned SW   = ihbrs_pkg::STEP_W;
	localparam int unsigned EW   = ihbrs_pkg::EMIT_W;
	localparam int unsigned LW   = ihbrs_pkg::LATE_W;
	localparam int unsigned GW   = CW + 2;
	localparam logic [GW-1:0] CPS_G  = GW'(ihbrs_pkg::CYCLES_PER_SECOND);
	localparam logic [SW-1:0] DIV_N  = SW'(ihbrs_pkg::DIV_STEPS);
	localparam logic [EW-1:0] EMIT_MAX = EW'(ihbrs_pkg::MAX_REFILLS);
	localparam logic [CW-1:0] LATE_LIM = CW'(ihbrs_pkg::LATE_GAP);
	localparam logic [LW-1:0] LATE_SAT = {LW{1'b1}};
	localparam int unsigned PAD  = QW - CW;

	// wrapped distance of two reduced cycle numbers
	function automatic logic [CW-1:0] wrap_gap(input logic [CW-1:0] newer,
		input logic [CW-1:0] older);
		logic [GW-1:0] s;
		s = {2'b00, newer} + CPS_G - {2'b00, older};
		if (s >= CPS_G) begin
			s = s - CPS_G;
		end
		return s[CW-1:0];
	endfunction

	// reduce a raw cycle number; raw values stay below twice the cycles per second
	function automatic logic [CW-1:0] cyc_mod(input logic [CW-1:0] raw);
		logic [GW-1:0] w;
		w = {2'b00, raw};
		if (w >= CPS_G) begin
			w = w - CPS_G;
		end
		return w[CW-1:0];
	endfunction

	ihbrs_pkg::state_t state_q;

	// configuration
	logic [CW-1:0] start_q, first_q, half_q;
	logic          enabled_q;
	logic          prev_from_start_q;

	// stream state
	logic [CW-1:0] prev_q;
	logic [QW-1:0] cycles_seen_q;
	logic          lead_passed_q;
	logic [QW-1:0] halves_done_q;
	logic [LW-1:0] late_total_q;

	// per-poll working registers
	logic [CW-1:0] cur_m_q, start_m_q, first_m_q, gap_q, lead_q;
	logic          late_q;
	logic [EW-1:0] emitted_q;

	// shared divide step unit
	logic [QW-1:0] div_q;
	logic [CW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [SW-1:0] cnt_q;
	logic [DW-1:0] trial, rem_sub;
	logic          ge;
	logic [CW-1:0] rem_nxt;
	logic [QW-1:0] div_nxt;
	logic          step_last;

	logic [CW-1:0] prev_eff;
	logic [CW-1:0] gap_now;
	logic [QW-1:0] lead_diff;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign trial     = {rem_q, div_q[QW-1]};
	assign ge        = (trial >= dvs_q);
	assign rem_sub   = trial - dvs_q;
	assign rem_nxt   = ge ? rem_sub[CW-1:0] : trial[CW-1:0];
	assign div_nxt   = {div_q[QW-2:0], ge};
	assign step_last = (cnt_q == SW'(1));

	assign prev_eff  = prev_from_start_q ? start_m_q : prev_q;
	assign gap_now   = wrap_gap(cur_m_q, prev_eff);
	assign lead_diff = cycles_seen_q - {{PAD{1'b0}}, lead_q};

	// handshake and result fields
	assign in_ready        = (state_q == ihbrs_pkg::S_IDLE);
	assign out_valid       = (state_q == ihbrs_pkg::S_REFILL) ||
	                         (state_q == ihbrs_pkg::S_STATUS);
	assign is_refill       = (state_q == ihbrs_pkg::S_REFILL);
	assign half_index      = is_refill & halves_done_q[0];
	assign packet_offset   = half_index ? half_q : '0;
	assign late_poll       = is_refill ? 1'b0 : late_q;
	assign late_poll_count = is_refill ? '0 : late_total_q;
	assign last            = (state_q == ihbrs_pkg::S_STATUS);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= '0;
			first_q   <= '0;
			half_q    <= CW'(ihbrs_pkg::HALF_RESET);
			enabled_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ihbrs_pkg::REG_START_CYCLE:    start_q   <= cfg_data;
				ihbrs_pkg::REG_FIRST_TX_CYCLE: first_q   <= cfg_data;
				ihbrs_pkg::REG_HALF_PACKETS:   half_q    <= cfg_data;
				ihbrs_pkg::REG_ENABLED:        enabled_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ihbrs_pkg::S_IDLE;
			prev_from_start_q <= 1'b0;
			prev_q            <= '0;
			cycles_seen_q     <= '0;
			lead_passed_q     <= 1'b0;
			halves_done_q     <= '0;
			late_total_q      <= '0;
			late_q            <= 1'b0;
			emitted_q         <= '0;
			cnt_q             <= '0;
		end else begin
			// a start write reloads the previous cycle on the next poll
			if (cfg_we && cfg_index == ihbrs_pkg::REG_START_CYCLE) begin
				prev_from_start_q <= 1'b1;
			end
			case (state_q)
				ihbrs_pkg::S_IDLE: begin
					if (in_valid) begin
						if (!enabled_q || half_q == '0) begin
							late_q  <= 1'b0;
							state_q <= ihbrs_pkg::S_STATUS;
						end else begin
							state_q <= ihbrs_pkg::S_GAP;
						end
					end
				end
				ihbrs_pkg::S_GAP: begin
					prev_q            <= cur_m_q;
					prev_from_start_q <= 1'b0;
					if (gap_now > LATE_LIM) begin
						late_q <= 1'b1;
						if (late_total_q != LATE_SAT) begin
							late_total_q <= late_total_q + LW'(1);
						end
					end else begin
						late_q <= 1'b0;
					end
					state_q <= ihbrs_pkg::S_ACC;
				end
				ihbrs_pkg::S_ACC: begin
					cycles_seen_q <= cycles_seen_q + {{PAD{1'b0}}, gap_q};
					state_q       <= ihbrs_pkg::S_LEAD;
				end
				ihbrs_pkg::S_LEAD: begin
					emitted_q <= '0;
					if (!lead_passed_q && cycles_seen_q < {{PAD{1'b0}}, lead_q}) begin
						state_q <= ihbrs_pkg::S_STATUS;
					end else begin
						lead_passed_q <= 1'b1;
						cnt_q         <= DIV_N;
						state_q       <= ihbrs_pkg::S_DIV;
					end
				end
				ihbrs_pkg::S_DIV: begin
					cnt_q <= cnt_q - SW'(1);
					if (step_last) begin
						state_q <= ihbrs_pkg::S_CMP;
					end
				end
				ihbrs_pkg::S_CMP: begin
					// div_q holds the number of halves owed by now
					if (halves_done_q < div_q && emitted_q != EMIT_MAX) begin
						state_q <= ihbrs_pkg::S_REFILL;
					end else begin
						state_q <= ihbrs_pkg::S_STATUS;
					end
				end
				ihbrs_pkg::S_REFILL: begin
					if (out_ready) begin
						halves_done_q <= halves_done_q + QW'(1);
						emitted_q     <= emitted_q + EW'(1);
						state_q       <= ihbrs_pkg::S_CMP;
					end
				end
				ihbrs_pkg::S_STATUS: begin
					if (out_ready) begin
						state_q <= ihbrs_pkg::S_IDLE;
					end
				end
				default: state_q <= ihbrs_pkg::S_IDLE;
			endcase
		end
	end

	// divide unit operands and per-poll payload
	always_ff @(posedge clk) begin
		case (state_q)
			ihbrs_pkg::S_IDLE: begin
				cur_m_q   <= cyc_mod(current_cycle);
				start_m_q <= cyc_mod(start_q);
				first_m_q <= cyc_mod(first_q);
			end
			ihbrs_pkg::S_GAP: begin
				gap_q  <= gap_now;
				lead_q <= wrap_gap(first_m_q, start_m_q);
			end
			ihbrs_pkg::S_LEAD: begin
				div_q <= lead_diff;
				rem_q <= '0;
				dvs_q <= {1'b0, half_q};
			end
			ihbrs_pkg::S_DIV: begin
				div_q <= div_nxt;
				rem_q <= rem_nxt;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire
